// File: hdl/b2b_pkg.sv
// Package with the constants, tables, types and helper functions of the BLAKE2b block.
package b2b_pkg;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 64;
   localparam int WORD_W     = 64;
   localparam int MSG_WORDS  = 16;
   localparam int LEN_W      = 8;
   localparam int DLEN_W     = 7;
   localparam int ADDR_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int ROUNDS     = 12;

   localparam logic [WORD_W-1:0] IV [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [WORD_W-1:0] PARAM_WORD = 64'h0000_0000_0101_0000;
   localparam logic [WORD_W-1:0] FINAL_FLAG = 64'hFFFF_FFFF_FFFF_FFFF;

   // Quarter steps of one mixing function.
   localparam logic [1:0] PH_A1 = 2'd0;
   localparam logic [1:0] PH_C1 = 2'd1;
   localparam logic [1:0] PH_A2 = 2'd2;
   localparam logic [1:0] PH_C2 = 2'd3;

   // Mix steps after which the rows are turned to and from the diagonal layout.
   localparam logic [2:0] STEP_DIAG   = 3'd3;
   localparam logic [2:0] STEP_UNDIAG = 3'd7;

   localparam logic [DLEN_W-1:0] DLEN_MAX = 7'd64;
   localparam logic [DLEN_W-1:0] DLEN_MIN = 7'd1;

   typedef struct packed {
      logic                 load_we;
      logic [ADDR_W-1:0]    load_addr;
      logic                 load_last;
      logic [COUNT_W-1:0]   count;
      logic                 init;
      logic                 mix;
      logic [1:0]           phase;
      logic [2:0]           step;
      logic                 fin;
      logic                 shift;
      logic [ADDR_W-1:0]    rd_addr;
   } cmd_type;

   typedef struct packed {
      logic [3:0] nres;
   } sts_type;

   // Message word schedule of one round, entry zero in the lowest nibble.
   function automatic logic [ADDR_W-1:0] perm_sel(input logic [3:0] round,
                                                  input logic [3:0] pos);
      logic [63:0] row;
      case (round)
         4'd0, 4'd10: row = 64'hFEDCBA9876543210;
         4'd1, 4'd11: row = 64'h357B20C16DF984AE;
         4'd2:        row = 64'h491763EADF250C8B;
         4'd3:        row = 64'h8F04A562EBCD1397;
         4'd4:        row = 64'hD386CB1EFA427509;
         4'd5:        row = 64'h91EF57D438B0A6C2;
         4'd6:        row = 64'hB8293670A4DEF15C;
         4'd7:        row = 64'hA2684F05931CE7BD;
         4'd8:        row = 64'h5A417D2C803B9EF6;
         4'd9:        row = 64'h0DC3E9BF5167482A;
         default:     row = 64'hFEDCBA9876543210;
      endcase
      return row[{pos, 2'b00} +: 4];
   endfunction

   // Keeps the bytes of word idx that lie below total bytes.
   function automatic logic [WORD_W-1:0] keep_mask(input logic [LEN_W-1:0] total,
                                                   input logic [3:0] idx);
      logic [LEN_W-1:0] start;
      logic [LEN_W-1:0] diff;
      logic [3:0]       nb;
      logic [WORD_W-1:0] mask;
      start = {1'b0, idx, 3'b000};
      diff  = total - start;
      if (total <= start) begin
         nb = 4'd0;
      end else if (diff >= 8'd8) begin
         nb = 4'd8;
      end else begin
         nb = diff[3:0];
      end
      for (int j = 0; j < 8; j++) begin
         mask[8*j +: 8] = (4'(j) < nb) ? 8'hFF : 8'h00;
      end
      return mask;
   endfunction

endpackage

// File: hdl/b2b_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module b2b_ram #(
   parameter int Width     = 64,
   parameter int Depth     = 16,
   parameter int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AddrWidth-1:0] waddr,
   input  logic [Width-1:0]     wdata,
   input  logic [AddrWidth-1:0] raddr,
   output logic [Width-1:0]     rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/b2b_dpath.sv
// Datapath of the BLAKE2b block: message store, work vector, mixing unit and digest output.
module b2b_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  b2b_pkg::cmd_type                cmd,
   output b2b_pkg::sts_type                sts,
   input  logic [b2b_pkg::WORD_W-1:0]      msg_word,
   input  logic [b2b_pkg::LEN_W-1:0]       msg_len,
   input  logic                            csr_we,
   input  logic [b2b_pkg::DLEN_W-1:0]      csr_wdata,
   output logic [b2b_pkg::WORD_W-1:0]      digest_word
);
   import b2b_pkg::*;

   logic [DLEN_W-1:0] digest_len_ff;
   logic [DLEN_W-1:0] dlen;
   logic [DLEN_W-1:0] dlen_sum;
   logic [LEN_W-1:0]  len_ff;
   logic [WORD_W-1:0] mask_ff;
   logic [WORD_W-1:0] mask_in;
   logic [WORD_W-1:0] ram_rdata;
   logic [WORD_W-1:0] mw;
   logic [WORD_W-1:0] h [8];
   logic [WORD_W-1:0] v_ff [16];
   logic [WORD_W-1:0] v_in [16];
   logic [WORD_W-1:0] t [16];
   logic [WORD_W-1:0] sum_a;
   logic [WORD_W-1:0] sum_c;
   logic [1:0]        rot_amt [4];

   function automatic logic [WORD_W-1:0] ror32(input logic [WORD_W-1:0] x);
      return {x[31:0], x[63:32]};
   endfunction

   function automatic logic [WORD_W-1:0] ror24(input logic [WORD_W-1:0] x);
      return {x[23:0], x[63:24]};
   endfunction

   function automatic logic [WORD_W-1:0] ror16(input logic [WORD_W-1:0] x);
      return {x[15:0], x[63:16]};
   endfunction

   function automatic logic [WORD_W-1:0] ror63(input logic [WORD_W-1:0] x);
      return {x[62:0], x[63]};
   endfunction

   b2b_ram #(
      .Width (WORD_W),
      .Depth (MSG_WORDS)
   ) u_msg_ram (
      .clock (clock),
      .we    (cmd.load_we),
      .waddr (cmd.load_addr),
      .wdata (msg_word),
      .raddr (cmd.rd_addr),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (digest_len_ff == '0) begin
         dlen = DLEN_MIN;
      end else if (digest_len_ff > DLEN_MAX) begin
         dlen = DLEN_MAX;
      end else begin
         dlen = digest_len_ff;
      end
   end

   assign dlen_sum = dlen + 7'd7;
   assign sts.nres = dlen_sum[6:3];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         h[i] = IV[i];
      end
      h[0] = IV[0] ^ PARAM_WORD ^ {{(WORD_W-DLEN_W){1'b0}}, dlen};
   end

   // Words past the fill count were never written in this message and read as zero.
   always_comb begin
      if ({1'b0, cmd.rd_addr} < cmd.count) begin
         mask_in = keep_mask(len_ff, cmd.rd_addr);
      end else begin
         mask_in = '0;
      end
   end

   assign mw = ram_rdata & mask_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         if (cmd.step == STEP_DIAG) begin
            rot_amt[r] = 2'(r + 1);
         end else if (cmd.step == STEP_UNDIAG) begin
            rot_amt[r] = 2'(1 - r);
         end else begin
            rot_amt[r] = 2'd1;
         end
      end
   end

   assign sum_a = v_ff[0] + v_ff[4] + mw;
   assign sum_c = v_ff[8] + v_ff[12];

   always_comb begin
      t = v_ff;
      t[8] = sum_c;
      t[4] = ror63(v_ff[4] ^ sum_c);
   end

   always_comb begin
      v_in = v_ff;
      if (cmd.init) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i]     = h[i];
            v_in[i + 8] = IV[i];
         end
         v_in[12] = IV[4] ^ {{(WORD_W-LEN_W){1'b0}}, len_ff};
         v_in[14] = IV[6] ^ FINAL_FLAG;
      end else if (cmd.mix) begin
         case (cmd.phase)
            PH_A1: begin
               v_in[0]  = sum_a;
               v_in[12] = ror32(v_ff[12] ^ sum_a);
            end
            PH_C1: begin
               v_in[8] = sum_c;
               v_in[4] = ror24(v_ff[4] ^ sum_c);
            end
            PH_A2: begin
               v_in[0]  = sum_a;
               v_in[12] = ror16(v_ff[12] ^ sum_a);
            end
            PH_C2: begin
               for (int r = 0; r < 4; r++) begin
                  for (int col = 0; col < 4; col++) begin
                     v_in[4*r + col] = t[4*r + ((col + int'(rot_amt[r])) & 3)];
                  end
               end
            end
            default: begin
               v_in = v_ff;
            end
         endcase
      end else if (cmd.fin) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = (h[i] ^ v_ff[i] ^ v_ff[i + 8]) & keep_mask({1'b0, dlen}, 4'(i));
         end
      end else if (cmd.shift) begin
         for (int i = 0; i < 7; i++) begin
            v_in[i] = v_ff[i + 1];
         end
         v_in[7] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digest_len_ff <= DLEN_MAX;
      end else if (csr_we) begin
         digest_len_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_last) begin
         len_ff <= msg_len;
      end
      mask_ff <= mask_in;
      v_ff    <= v_in;
   end

   assign digest_word = v_ff[0];

endmodule

// File: hdl/b2b_ctrl.sv
// Controller of the BLAKE2b block: load, mixing schedule and digest output sequencing.
module b2b_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_tlast,
   output b2b_pkg::cmd_type cmd,
   input  b2b_pkg::sts_type sts
);
   import b2b_pkg::*;

   typedef enum logic [4:0] {
      S_LOAD  = 5'b00001,
      S_INIT  = 5'b00010,
      S_MIX   = 5'b00100,
      S_FINAL = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         round_ff, round_in;
   logic [2:0]         step_ff, step_in;
   logic [1:0]         phase_ff, phase_in;
   logic [2:0]         out_idx_ff, out_idx_in;
   logic [COUNT_W-1:0] words_loaded_ff, words_loaded_in;
   logic               req_acc;
   logic               rsp_acc;
   logic               mix_done;

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tlast  = ({1'b0, out_idx_ff} == sts.nres - 4'd1);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign mix_done   = (phase_ff == PH_C2) && (step_ff == 3'd7) &&
                       (round_ff == 4'(ROUNDS - 1));

   always_comb begin
      state_in        = state_ff;
      round_in        = round_ff;
      step_in         = step_ff;
      phase_in        = phase_ff;
      out_idx_in      = out_idx_ff;
      words_loaded_in = words_loaded_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (words_loaded_ff < 5'(MSG_WORDS)) begin
                  words_loaded_in = words_loaded_ff + 5'd1;
               end
               if (req_tlast) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            state_in = S_MIX;
         end
         S_MIX: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == PH_C2) begin
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  round_in = round_ff + 4'd1;
               end
            end
            if (mix_done) begin
               state_in = S_FINAL;
               round_in = '0;
               step_in  = '0;
               phase_in = '0;
            end
         end
         S_FINAL: begin
            state_in   = S_OUT;
            out_idx_in = '0;
         end
         S_OUT: begin
            if (rsp_acc) begin
               if (rsp_tlast) begin
                  state_in        = S_LOAD;
                  words_loaded_in = '0;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_LOAD;
         round_ff        <= '0;
         step_ff         <= '0;
         phase_ff        <= '0;
         out_idx_ff      <= '0;
         words_loaded_ff <= '0;
      end else begin
         state_ff        <= state_in;
         round_ff        <= round_in;
         step_ff         <= step_in;
         phase_ff        <= phase_in;
         out_idx_ff      <= out_idx_in;
         words_loaded_ff <= words_loaded_in;
      end
   end

   always_comb begin
      cmd.load_we   = req_acc && (words_loaded_ff < 5'(MSG_WORDS));
      cmd.load_addr = words_loaded_ff[ADDR_W-1:0];
      cmd.load_last = req_acc && req_tlast;
      cmd.count     = words_loaded_ff;
      cmd.init      = (state_ff == S_INIT);
      cmd.mix       = (state_ff == S_MIX);
      cmd.phase     = phase_ff;
      cmd.step      = step_ff;
      cmd.fin       = (state_ff == S_FINAL);
      cmd.shift     = rsp_acc;
      cmd.rd_addr   = perm_sel(round_in, {step_in, phase_in[1]});
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MIX && mix_done) |=> (state_ff == S_FINAL))
      else $error("Mixing did not end after the last round.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL) |=> (state_ff == S_OUT && out_idx_ff == 3'd0))
      else $error("Digest output did not start at the first word.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (round_ff == 4'd0 && step_ff == 3'd0 && phase_ff == 2'd0))
      else $error("Mixing counters not at rest while loading.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_tlast) |=> (state_ff == S_LOAD && words_loaded_ff == '0))
      else $error("Block did not return to loading after the last digest word.");

endmodule

// File: hdl/blake2b_single_block_hash.sv
// Top level of the single-block unkeyed BLAKE2b hash.
// After the request with tlast come a setup state, the mixing of 12 rounds of 8 mixes (4
// quarter steps per mix in the shared mixing unit) and a finalize state, then the first
// digest word; the remaining ceil(digest_len/8)-1 words follow one per accepted cycle.
// A new message is taken only after the last digest word of the previous one is accepted.
// Reset is synchronous and active high; it clears the message word count and sets digest_len 64.
module blake2b_single_block_hash (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [b2b_pkg::REQ_DATA_W-1:0]    req_tdata,   // msg_word, msg_len
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [b2b_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // digest_word
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [b2b_pkg::DLEN_W-1:0]        csr_wdata
);
   import b2b_pkg::*;

   cmd_type cmd;
   sts_type sts;

   b2b_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

   b2b_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .msg_word    (req_tdata[WORD_W-1:0]),
      .msg_len     (req_tdata[WORD_W +: LEN_W]),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .digest_word (rsp_tdata)
   );

endmodule
